// ===== rtl/min_priority_queue_defines.svh =====
// ----------------------------------------------------------------------------
// min_priority_queue_defines
// Assertion macros used by the queue top level.
// ----------------------------------------------------------------------------
`ifndef MIN_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_PRIORITY_QUEUE_DEFINES_SVH

// check that a implies b in the same cycle
`define MPQ_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// check that a implies b in the next cycle
`define MPQ_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== rtl/mpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mpq_pkg
// Types and constants of the minimum priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package mpq_pkg;

  localparam int CAPACITY  = 2048;
  localparam int KEY_WIDTH = 32;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_INS,
    S_SRD,
    S_SCMP,
    S_LRD,
    S_MOVE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] key;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_key;
    logic [1:0]  status;
    logic [11:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic cap;
    logic wr_ins;
    logic scan_start;
    logic rd_idx;
    logic cmp;
    logic rd_last;
    logic wr_move;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] status;
    logic       scan_last;
    logic       out_free;
  } stat_t;

endpackage

// ===== rtl/mpq_datapath.sv =====
// ----------------------------------------------------------------------------
// mpq_datapath
// Key memory, entry count, minimum scan registers and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mpq_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mpq_pkg::in_item_t   in_i,
  input  mpq_pkg::cmd_t       cmd_i,
  output mpq_pkg::stat_t      stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mpq_pkg::out_item_t  out_o
);

  logic [mpq_pkg::KEY_WIDTH-1:0] mem [mpq_pkg::CAPACITY];

  logic [mpq_pkg::CNT_W-1:0]     count_q;
  logic [mpq_pkg::ADDR_W-1:0]    idx_q;
  logic [mpq_pkg::ADDR_W-1:0]    slot_q;
  logic [mpq_pkg::KEY_WIDTH-1:0] best_q;
  logic [mpq_pkg::KEY_WIDTH-1:0] rd_data_q;
  logic [mpq_pkg::KEY_WIDTH-1:0] key_q;
  logic [1:0]                    op_q;
  logic [1:0]                    status_q;
  logic                          out_valid_q;
  mpq_pkg::out_item_t            out_q;

  logic [mpq_pkg::CNT_W-1:0]     count_m1;
  logic [mpq_pkg::ADDR_W-1:0]    wr_addr;
  logic [mpq_pkg::KEY_WIDTH-1:0] wr_data;
  logic [mpq_pkg::ADDR_W-1:0]    rd_addr;
  logic                          wr_en;
  logic                          rd_en;
  logic [1:0]                    status_d;

  assign count_m1 = mpq_pkg::CNT_W'(count_q - 1'b1);
  assign wr_en    = cmd_i.wr_ins | cmd_i.wr_move;
  assign wr_addr  = cmd_i.wr_ins ? count_q[mpq_pkg::ADDR_W-1:0] : slot_q;
  assign wr_data  = cmd_i.wr_ins ? key_q : rd_data_q;
  assign rd_en    = cmd_i.rd_idx | cmd_i.rd_last;
  assign rd_addr  = cmd_i.rd_idx ? idx_q : count_m1[mpq_pkg::ADDR_W-1:0];

  always_comb begin
    status_d = mpq_pkg::ST_OK;
    case (in_i.operation)
      mpq_pkg::OP_INSERT: begin
        if (count_q >= mpq_pkg::CNT_W'(mpq_pkg::CAPACITY)) status_d = mpq_pkg::ST_FULL;
      end
      mpq_pkg::OP_POP, mpq_pkg::OP_PEEK: begin
        if (count_q == '0) status_d = mpq_pkg::ST_EMPTY;
      end
      default: status_d = mpq_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q     <= in_i.operation;
      key_q    <= mpq_pkg::KEY_WIDTH'(in_i.key);
      status_q <= status_d;
    end
    if (cmd_i.scan_start) idx_q <= '0;
    if (cmd_i.cmp) begin
      if (idx_q == '0 || rd_data_q < best_q) begin
        best_q <= rd_data_q;
        slot_q <= idx_q;
      end
      idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.load_out) begin
      out_q.status      <= status_q;
      out_q.entry_count <= 12'(count_q);
      if ((op_q == mpq_pkg::OP_POP || op_q == mpq_pkg::OP_PEEK) &&
          status_q == mpq_pkg::ST_OK) begin
        out_q.result_key <= 32'(best_q);
      end else begin
        out_q.result_key <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr_ins) count_q <= count_q + 1'b1;
      else if (cmd_i.wr_move) count_q <= count_m1;
      if (cmd_i.load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign stat_o.op        = op_q;
  assign stat_o.status    = status_q;
  assign stat_o.scan_last = ({1'b0, idx_q} == count_m1);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_o            = out_q;

endmodule

// ===== rtl/mpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpq_ctrl
// Sequencer for insert, scan for minimum, pop repair and result delivery.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mpq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output mpq_pkg::cmd_t   cmd_o,
  input  mpq_pkg::stat_t  stat_i
);

  mpq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= mpq_pkg::S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      mpq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = mpq_pkg::S_DEC;
        end
      end
      mpq_pkg::S_DEC: begin
        if (stat_i.status != mpq_pkg::ST_OK) begin
          state_d = mpq_pkg::S_DONE;
        end else if (stat_i.op == mpq_pkg::OP_INSERT) begin
          state_d = mpq_pkg::S_INS;
        end else if (stat_i.op == mpq_pkg::OP_POP || stat_i.op == mpq_pkg::OP_PEEK) begin
          cmd_o.scan_start = 1'b1;
          state_d          = mpq_pkg::S_SRD;
        end else begin
          state_d = mpq_pkg::S_DONE;
        end
      end
      mpq_pkg::S_INS: begin
        cmd_o.wr_ins = 1'b1;
        state_d      = mpq_pkg::S_DONE;
      end
      mpq_pkg::S_SRD: begin
        cmd_o.rd_idx = 1'b1;
        state_d      = mpq_pkg::S_SCMP;
      end
      mpq_pkg::S_SCMP: begin
        cmd_o.cmp = 1'b1;
        if (!stat_i.scan_last) state_d = mpq_pkg::S_SRD;
        else if (stat_i.op == mpq_pkg::OP_POP) state_d = mpq_pkg::S_LRD;
        else state_d = mpq_pkg::S_DONE;
      end
      mpq_pkg::S_LRD: begin
        cmd_o.rd_last = 1'b1;
        state_d       = mpq_pkg::S_MOVE;
      end
      mpq_pkg::S_MOVE: begin
        cmd_o.wr_move = 1'b1;
        state_d       = mpq_pkg::S_DONE;
      end
      mpq_pkg::S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = mpq_pkg::S_IDLE;
        end
      end
      default: state_d = mpq_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== rtl/min_priority_queue.sv =====
// ----------------------------------------------------------------------------
// min_priority_queue
// Minimum priority queue of unsigned keys held in an unordered key memory.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_ready_o  in_i  (operation, key)
//   out      output     out_valid_o / out_ready_i out_o (result_key, status, entry_count)
//
// Peek scans every entry; pop also moves the last entry into the freed slot.
// The scan reads the key memory through its single registered read port,
// with a read state and a compare state per entry. Reset clears the count
// and the output flag; the key memory is not cleared. A stalled result
// holds the sequencer in its final state until the output register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "min_priority_queue_defines.svh"
module min_priority_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mpq_pkg::in_item_t   in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mpq_pkg::out_item_t  out_o
);

  mpq_pkg::cmd_t  cmd;
  mpq_pkg::stat_t stat;

  mpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  mpq_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  `MPQ_ASSERT_IMPLY(a_count_range, clk_i, rst_ni, out_valid_o,
                    out_o.entry_count <= 12'(mpq_pkg::CAPACITY))
  `MPQ_ASSERT_IMPLY(a_full_count, clk_i, rst_ni,
                    out_valid_o && out_o.status == mpq_pkg::ST_FULL,
                    out_o.entry_count == 12'(mpq_pkg::CAPACITY) && out_o.result_key == '0)
  `MPQ_ASSERT_IMPLY(a_empty_count, clk_i, rst_ni,
                    out_valid_o && out_o.status == mpq_pkg::ST_EMPTY,
                    out_o.entry_count == '0 && out_o.result_key == '0)
  `MPQ_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o,
                   !in_ready_o)

endmodule

// ===== dv/mpq_checker.sv =====
// ----------------------------------------------------------------------------
// mpq_checker
// Watches both channels of the minimum priority queue. It keeps its own
// unordered key store and entry count, and predicts one result for each
// accepted input item. Each accepted result is compared field by field with
// the oldest prediction. It reports the number of failures and the number
// of results still outstanding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mpq_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  mpq_pkg::in_item_t   in_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  mpq_pkg::out_item_t  out_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import mpq_pkg::*;

  logic [KEY_WIDTH-1:0] held_keys [CAPACITY];
  int unsigned          held_num;
  out_item_t            result_fifo [$];
  int                   fails;

  assign fail_count_o = fails;
  assign pending_o    = result_fifo.size();

  function automatic out_item_t apply_op(in_item_t item);
    out_item_t   res;
    int unsigned best;
    res = '0;
    res.status = ST_OK;
    case (item.operation)
      OP_INSERT: begin
        if (held_num >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          held_keys[held_num] = item.key;
          held_num++;
        end
      end
      OP_POP, OP_PEEK: begin
        if (held_num == 0) begin
          res.status = ST_EMPTY;
        end else begin
          best = 0;
          for (int unsigned i = 1; i < held_num; i++)
            if (held_keys[i] < held_keys[best]) best = i;
          res.result_key = held_keys[best];
          if (item.operation == OP_POP) begin
            held_num--;
            held_keys[best] = held_keys[held_num];
          end
        end
      end
      default: ;
    endcase
    res.entry_count = held_num[11:0];
    return res;
  endfunction

  initial begin
    held_num = 0;
    fails    = 0;
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) result_fifo.push_back(apply_op(in_i));
      if (out_valid_i && out_ready_i) begin
        if (result_fifo.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result: key %h status %0d count %0d",
                                    out_i.result_key, out_i.status, out_i.entry_count);
        end else begin
          want = result_fifo.pop_front();
          if (want.result_key !== out_i.result_key || want.status !== out_i.status ||
              want.entry_count !== out_i.entry_count) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: key exp %h act %h, status exp %0d act %0d, count exp %0d act %0d",
                       want.result_key, out_i.result_key, want.status, out_i.status,
                       want.entry_count, out_i.entry_count);
          end
        end
      end
    end
  end
endmodule

// ===== dv/min_priority_queue_tb.sv =====
// ----------------------------------------------------------------------------
// min_priority_queue_tb
// Drives insert, pop, peek and unused operations into the queue under
// several idling patterns, including a long output stall and a fill to
// capacity, and takes the verdict from the checker beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module min_priority_queue_tb;

  localparam int WATCHDOG_LIMIT = 40000;

  logic               clk_i, rst_ni;
  logic               in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  mpq_pkg::in_item_t  in_i;
  mpq_pkg::out_item_t out_o;
  int                 fail_count, pending;
  int                 tx_pct, rx_pct, held_est, idle_cycles;
  bit                 hold_req;

  min_priority_queue dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_i(in_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_o(out_o)
  );

  mpq_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_i(in_ready_o), .in_i(in_i),
    .out_valid_i(out_valid_o), .out_ready_i(out_ready_i), .out_i(out_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    int hold_left;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rx_pct);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("min_priority_queue_tb failed");
        $finish;
      end
    end
  end

  task automatic send_item(logic [1:0] op, logic [31:0] key);
    if ($urandom_range(0, 99) < tx_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_i.operation <= op;
    in_i.key       <= key;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == mpq_pkg::OP_INSERT && held_est < mpq_pkg::CAPACITY) held_est++;
    if (op == mpq_pkg::OP_POP && held_est > 0) held_est--;
  endtask

  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(0, 7);
    if (r < 2) return $urandom_range(0, 15);
    if (r == 2) return ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
    return $urandom;
  endfunction

  task automatic random_items(int n);
    int r;
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) op = 2'd3;
      else if (r < 18) op = mpq_pkg::OP_PEEK;
      else if (r < ((held_est < 4) ? 85 : (held_est > 24) ? 40 : 60)) op = mpq_pkg::OP_INSERT;
      else op = mpq_pkg::OP_POP;
      send_item(op, (op == mpq_pkg::OP_INSERT) ? pick_key() : $urandom);
    end
  endtask

  task automatic fill_until(int target);
    while (held_est < target) send_item(mpq_pkg::OP_INSERT, $urandom);
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_i       = '0;
    tx_pct     = 0;
    rx_pct     = 0;
    held_est   = 0;
    hold_req   = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(mpq_pkg::OP_PEEK, 32'hFFFF_FFFF);
    send_item(mpq_pkg::OP_POP, 32'h1234_5678);
    send_item(2'd3, 32'hFFFF_FFFF);
    send_item(mpq_pkg::OP_INSERT, 32'hFFFF_FFFF);
    send_item(mpq_pkg::OP_INSERT, 32'h0000_0000);
    send_item(mpq_pkg::OP_INSERT, 32'h0000_0007);
    send_item(mpq_pkg::OP_INSERT, 32'h0000_0007);
    send_item(mpq_pkg::OP_INSERT, 32'h8000_0000);
    send_item(mpq_pkg::OP_PEEK, 32'h0);
    send_item(2'd3, 32'h5555_AAAA);
    repeat (6) send_item(mpq_pkg::OP_POP, 32'hAAAA_5555);
    send_item(mpq_pkg::OP_PEEK, 32'h0);
    send_item(mpq_pkg::OP_INSERT, 32'h7FFF_FFFF);
    send_item(mpq_pkg::OP_POP, 32'h0);

    tx_pct = 0;  rx_pct = 0;  random_items(25);
    tx_pct = 53; rx_pct = 0;  random_items(25);
    tx_pct = 0;  rx_pct = 53; random_items(25);
    tx_pct = 29; rx_pct = 29; random_items(25);

    tx_pct = 53; rx_pct = 0;  fill_until(mpq_pkg::CAPACITY / 4);
    tx_pct = 0;  rx_pct = 53; fill_until(mpq_pkg::CAPACITY / 2);
    tx_pct = 29; rx_pct = 29; fill_until(3 * mpq_pkg::CAPACITY / 4);

    tx_pct = 0; rx_pct = 0;
    hold_req = 1'b1;
    repeat (12) send_item(mpq_pkg::OP_INSERT, pick_key());
    fill_until(mpq_pkg::CAPACITY);
    send_item(mpq_pkg::OP_INSERT, 32'hFFFF_FFFF);
    send_item(mpq_pkg::OP_INSERT, 32'h0);
    send_item(mpq_pkg::OP_PEEK, 32'h0);
    send_item(mpq_pkg::OP_POP, 32'h0);
    send_item(mpq_pkg::OP_INSERT, 32'h0);
    send_item(mpq_pkg::OP_INSERT, 32'h1);
    send_item(mpq_pkg::OP_POP, 32'h0);
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("min_priority_queue_tb passed");
    end else begin
      $display("min_priority_queue_tb failed");
    end
    $finish;
  end
endmodule
